/* src/gdc_pkg.sv */
// Shared types and constants of the grid DDA wall caster.
package gdc_pkg;

  // Register indexes on the configuration port
  localparam logic REG_SCREEN_HEIGHT = 1'b0;
  localparam logic REG_VIEWPORT_TOP  = 1'b1;

  // Input action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd480;
  localparam logic [10:0] VIEWPORT_TOP_RST  = 11'd0;
  localparam logic [22:0] PERP_MAX          = 23'h7FFFFF;
  localparam logic [15:0] HEIGHT_MAX        = 16'hFFFF;
  // Dividend and quotient width of the shared divider (holds 2^30)
  localparam int          DIV_NW            = 31;
  // Delta of an axis with a zero direction component: 2^40
  localparam int          DELTA_W           = 41;

  // Classified item between front and back
  typedef struct packed {
    logic        is_cast;
    logic        wr_ok;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [2:0]  cell_value;
    logic [21:0] start_x;
    logic [21:0] start_y;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
  } gdc_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RECX,
    B_RECY,
    B_SIDE,
    B_WALK,
    B_LH,
    B_DRAW
  } gdc_state_t;

endpackage

/* src/grid_dda_wall_caster_top.sv */
// Top level of the grid DDA wall caster: config registers, front and back.
//
// Usage: items enter on start/busy; an item is taken at a clock edge with
// start high and busy low. action 0 writes one map cell (no result), action
// 1 casts a ray. Each cast yields one result on the out_ ports for a single
// cycle, marked by out_valid; the receiver cannot stall it.
// A two-entry queue sits between the front end and the back end, so busy
// rises only while both queue entries hold waiting items.
// A write completes in the back end as it is popped. A cast runs two
// reciprocals (each cut short for a zero component), side setup and a walk
// of S grid steps (S <= MAX_STEPS, one step a cycle with the map read
// overlapped), then the line height division (only on a hit) and the draw
// rows; the result strobe follows in the cycle after the draw rows. The
// restoring divider (load, shift steps, done) and the one-read-per-cycle
// map port set this pace.
// The user writes configuration over the APB-style port only while idle;
// the block does not enforce it. Reset clears queue, sequencer, registers
// (screen height 480, viewport top 0); map cells undefined until written.
module grid_dda_wall_caster_top #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64,
  parameter int MAX_STEPS  = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  input  logic [2:0]  in_cell_value,
  input  logic [21:0] in_start_x,
  input  logic [21:0] in_start_y,
  input  logic [15:0] in_dir_x,
  input  logic [15:0] in_dir_y,
  output logic        out_valid,
  output logic        out_wall_hit,
  output logic [5:0]  out_hit_x,
  output logic [5:0]  out_hit_y,
  output logic [2:0]  out_wall_type,
  output logic        out_hit_side,
  output logic [22:0] out_perp_distance,
  output logic [15:0] out_line_height,
  output logic [11:0] out_draw_start,
  output logic [11:0] out_draw_end
);

  logic [10:0]        cfg_height_r, cfg_top_r;
  logic               cfg_wr;
  logic               item_vld, item_pop;
  gdc_pkg::gdc_item_t item;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_height_r <= gdc_pkg::SCREEN_HEIGHT_RST;
      cfg_top_r    <= gdc_pkg::VIEWPORT_TOP_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        gdc_pkg::REG_SCREEN_HEIGHT: cfg_height_r <= pwdata[10:0];
        gdc_pkg::REG_VIEWPORT_TOP:  cfg_top_r    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[2])
      gdc_pkg::REG_SCREEN_HEIGHT: prdata = {21'd0, cfg_height_r};
      gdc_pkg::REG_VIEWPORT_TOP:  prdata = {21'd0, cfg_top_r};
      default:                    prdata = 32'd0;
    endcase
  end

  gdc_front #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_cell_x    (in_cell_x),
    .in_cell_y    (in_cell_y),
    .in_cell_value(in_cell_value),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_dir_x     (in_dir_x),
    .in_dir_y     (in_dir_y),
    .item_vld     (item_vld),
    .item         (item),
    .item_pop     (item_pop)
  );

  gdc_back #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT),
             .MAX_STEPS(MAX_STEPS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_vld         (item_vld),
    .item             (item),
    .item_pop         (item_pop),
    .screen_height    (cfg_height_r),
    .viewport_top     (cfg_top_r),
    .out_valid        (out_valid),
    .out_wall_hit     (out_wall_hit),
    .out_hit_x        (out_hit_x),
    .out_hit_y        (out_hit_y),
    .out_wall_type    (out_wall_type),
    .out_hit_side     (out_hit_side),
    .out_perp_distance(out_perp_distance),
    .out_line_height  (out_line_height),
    .out_draw_start   (out_draw_start),
    .out_draw_end     (out_draw_end)
  );

endmodule

/* src/gdc_front.sv */
// Front end: accepts items, classifies them and queues them for the back end.
module gdc_front #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [5:0]         in_cell_x,
  input  logic [5:0]         in_cell_y,
  input  logic [2:0]         in_cell_value,
  input  logic [21:0]        in_start_x,
  input  logic [21:0]        in_start_y,
  input  logic [15:0]        in_dir_x,
  input  logic [15:0]        in_dir_y,
  output logic               item_vld,
  output gdc_pkg::gdc_item_t item,
  input  logic               item_pop
);

  gdc_pkg::gdc_item_t q_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;
  logic               push;
  gdc_pkg::gdc_item_t cls;

  // Classify: mark casts and writes that land inside the map
  always_comb begin
    cls.is_cast    = (in_action == gdc_pkg::ACT_CAST);
    cls.wr_ok      = (9'(in_cell_x) < 9'(MAP_WIDTH)) && (9'(in_cell_y) < 9'(MAP_HEIGHT));
    cls.cell_x     = in_cell_x;
    cls.cell_y     = in_cell_y;
    cls.cell_value = in_cell_value;
    cls.start_x    = in_start_x;
    cls.start_y    = in_start_y;
    cls.dir_x      = in_dir_x;
    cls.dir_y      = in_dir_y;
  end

  assign busy     = (cnt_r == 2'd2);
  assign push     = start && !busy;
  assign item_vld = (cnt_r != 2'd0);
  assign item     = q_r[rp_r];

  // Store payload
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (item_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(item_pop);
    end
  end

endmodule

/* src/gdc_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the back end.
module gdc_div #(
  parameter int NW = 31,
  parameter int DW = 49
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fit;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fit   = (trial >= {1'b0, den_r});
  assign quo   = quo_r;
  assign done  = done_r;

  // Shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= fit ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      quo_r <= {quo_r[NW-2:0], fit};
    end
  end

  // Count steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/gdc_back.sv */
// Back end: map store, ray setup, DDA walk and line height sequencer.
module gdc_back #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64,
  parameter int MAX_STEPS  = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_vld,
  input  gdc_pkg::gdc_item_t item,
  output logic               item_pop,
  input  logic [10:0]        screen_height,
  input  logic [10:0]        viewport_top,
  output logic               out_valid,
  output logic               out_wall_hit,
  output logic [5:0]         out_hit_x,
  output logic [5:0]         out_hit_y,
  output logic [2:0]         out_wall_type,
  output logic               out_hit_side,
  output logic [22:0]        out_perp_distance,
  output logic [15:0]        out_line_height,
  output logic [11:0]        out_draw_start,
  output logic [11:0]        out_draw_end
);

  localparam int XW    = $clog2(MAP_WIDTH);
  localparam int YW    = $clog2(MAP_HEIGHT);
  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = gdc_pkg::DIV_NW;
  localparam int SW    = gdc_pkg::DELTA_W + $clog2(MAX_STEPS + 1);
  localparam int KW    = $clog2(MAX_STEPS + 1);

  gdc_pkg::gdc_state_t state_r, state_nxt;

  logic [2:0]    map_mem [DEPTH];
  logic [2:0]    rd_r;

  // Ray setup registers
  logic          negx_r, negy_r;
  logic [16:0]   magx_r, magy_r;
  logic [16:0]   fx_r, fy_r;
  logic [XW-1:0] cx_r;
  logic [YW-1:0] cy_r;
  logic [SW-1:0] ddx_r, ddy_r, sdx_r, sdy_r;
  logic          div_run_r;

  // Walk registers
  logic [KW-1:0] issued_r;
  logic          chk_vld_r;
  logic [XW-1:0] chk_cx_r;
  logic [YW-1:0] chk_cy_r;
  logic          chk_side_r;
  logic [SW-1:0] chk_perp_r;
  logic          hit_r;
  logic [15:0]   lh_r;

  logic          out_valid_r;
  logic          out_hit_r, out_side_r;
  logic [5:0]    out_x_r, out_y_r;
  logic [2:0]    out_type_r;
  logic [22:0]   out_perp_r;
  logic [15:0]   out_lh_r;
  logic [11:0]   out_ds_r, out_de_r;

  // Divider hookup
  logic          div_go, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [SW-1:0] div_den;

  gdc_div #(.NW(NW), .DW(SW)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // Axis setup of the popped item
  logic          inx, iny;
  logic [16:0]   imx, imy, ifx, ify;
  logic [8:0]    icx, icy;
  always_comb begin
    inx = item.dir_x[15];
    iny = item.dir_y[15];
    imx = inx ? 17'(17'h10000 - {1'b0, item.dir_x}) : {1'b0, item.dir_x};
    imy = iny ? 17'(17'h10000 - {1'b0, item.dir_y}) : {1'b0, item.dir_y};
    ifx = inx ? {1'b0, item.start_x[15:0]} : 17'(17'h10000 - {1'b0, item.start_x[15:0]});
    ify = iny ? {1'b0, item.start_y[15:0]} : 17'(17'h10000 - {1'b0, item.start_y[15:0]});
    icx = (9'(item.start_x[21:16]) > 9'(MAP_WIDTH - 1)) ? 9'(MAP_WIDTH - 1)
                                                        : 9'(item.start_x[21:16]);
    icy = (9'(item.start_y[21:16]) > 9'(MAP_HEIGHT - 1)) ? 9'(MAP_HEIGHT - 1)
                                                         : 9'(item.start_y[21:16]);
  end

  // One DDA step from the current walk registers
  logic          step_x;
  logic [XW-1:0] ncx;
  logic [YW-1:0] ncy;
  logic [AW-1:0] raddr, waddr;
  logic          hit_now, walk_end;
  always_comb begin
    step_x = (sdx_r < sdy_r);
    ncx    = cx_r;
    ncy    = cy_r;
    if (step_x) begin
      if (negx_r) ncx = (cx_r == '0) ? cx_r : XW'(cx_r - 1'b1);
      else        ncx = (cx_r == XW'(MAP_WIDTH - 1)) ? cx_r : XW'(cx_r + 1'b1);
    end else begin
      if (negy_r) ncy = (cy_r == '0) ? cy_r : YW'(cy_r - 1'b1);
      else        ncy = (cy_r == YW'(MAP_HEIGHT - 1)) ? cy_r : YW'(cy_r + 1'b1);
    end
    hit_now  = chk_vld_r && (rd_r != 3'd0);
    walk_end = hit_now || (issued_r == KW'(MAX_STEPS));
    // Read the next cell while stepping, else hold on the final cell
    if (state_r == gdc_pkg::B_WALK && !walk_end)
      raddr = AW'(AW'(ncy) * AW'(MAP_WIDTH) + AW'(ncx));
    else
      raddr = AW'(AW'(cy_r) * AW'(MAP_WIDTH) + AW'(cx_r));
    waddr    = AW'(AW'(item.cell_y) * AW'(MAP_WIDTH) + AW'(item.cell_x));
  end

  // Map store
  logic map_we;
  assign map_we = (state_r == gdc_pkg::B_IDLE) && item_vld && !item.is_cast && item.wr_ok;
  always_ff @(posedge clk) begin
    if (map_we) map_mem[waddr] <= item.cell_value;
    rd_r <= map_mem[raddr];
  end

  // Draw rows from the line height
  logic [10:0] h_eff;
  logic [16:0] twice;
  logic [11:0] ds, top_h;
  logic [16:0] de_sum;
  logic [11:0] de;
  always_comb begin
    h_eff  = (screen_height == 11'd0) ? 11'd1 : screen_height;
    twice  = 17'({viewport_top, 1'b0}) + 17'({h_eff[10:1], 1'b0}) - 17'(lh_r);
    ds     = twice[16] ? 12'(viewport_top) : twice[12:1];
    if (ds < 12'(viewport_top)) ds = 12'(viewport_top);
    top_h  = 12'(viewport_top) + 12'(h_eff);
    de_sum = 17'(ds) + 17'(lh_r);
    de     = (de_sum >= 17'(top_h)) ? 12'(top_h - 12'd1) : de_sum[11:0];
  end

  // Sequence control
  always_comb begin
    state_nxt = state_r;
    item_pop  = 1'b0;
    div_go    = 1'b0;
    div_num   = NW'(1 << 30);
    div_den   = SW'(magx_r);
    case (state_r)
      gdc_pkg::B_IDLE: begin
        if (item_vld) begin
          item_pop = 1'b1;
          if (item.is_cast) state_nxt = gdc_pkg::B_RECX;
        end
      end
      gdc_pkg::B_RECX: begin
        div_go = (magx_r != 17'd0) && !div_run_r;
        if (magx_r == 17'd0 || div_done) state_nxt = gdc_pkg::B_RECY;
      end
      gdc_pkg::B_RECY: begin
        div_den = SW'(magy_r);
        div_go  = (magy_r != 17'd0) && !div_run_r;
        if (magy_r == 17'd0 || div_done) state_nxt = gdc_pkg::B_SIDE;
      end
      gdc_pkg::B_SIDE: state_nxt = gdc_pkg::B_WALK;
      gdc_pkg::B_WALK: begin
        if (walk_end) state_nxt = hit_now ? gdc_pkg::B_LH : gdc_pkg::B_DRAW;
      end
      gdc_pkg::B_LH: begin
        div_num = NW'({h_eff, 16'h0000});
        div_den = chk_perp_r;
        div_go  = !div_run_r;
        if (div_done) state_nxt = gdc_pkg::B_DRAW;
      end
      gdc_pkg::B_DRAW: state_nxt = gdc_pkg::B_IDLE;
      default: state_nxt = gdc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= gdc_pkg::B_IDLE;
    else        state_r <= state_nxt;
  end

  // Track an outstanding division
  always_ff @(posedge clk) begin
    if (!rst_n)        div_run_r <= 1'b0;
    else if (div_go)   div_run_r <= 1'b1;
    else if (div_done) div_run_r <= 1'b0;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      gdc_pkg::B_IDLE: begin
        negx_r <= inx;
        negy_r <= iny;
        magx_r <= imx;
        magy_r <= imy;
        fx_r   <= ifx;
        fy_r   <= ify;
        cx_r   <= XW'(icx);
        cy_r   <= YW'(icy);
      end
      gdc_pkg::B_RECX: begin
        if (magx_r == 17'd0) ddx_r <= SW'(1) << 40;
        else if (div_done)   ddx_r <= SW'(div_quo);
      end
      gdc_pkg::B_RECY: begin
        if (magy_r == 17'd0) ddy_r <= SW'(1) << 40;
        else if (div_done)   ddy_r <= SW'(div_quo);
      end
      gdc_pkg::B_SIDE: begin
        // Zero component: delta is a power of two, so the product is a shift
        sdx_r <= (magx_r == 17'd0) ? SW'(fx_r) << 24
                                   : SW'((48'(fx_r) * 48'(ddx_r[30:0])) >> 16);
        sdy_r <= (magy_r == 17'd0) ? SW'(fy_r) << 24
                                   : SW'((48'(fy_r) * 48'(ddy_r[30:0])) >> 16);
      end
      gdc_pkg::B_WALK: begin
        if (!walk_end) begin
          // Issue one step; its map read is checked next cycle
          if (step_x) sdx_r <= SW'(sdx_r + ddx_r);
          else        sdy_r <= SW'(sdy_r + ddy_r);
          cx_r       <= ncx;
          cy_r       <= ncy;
          chk_cx_r   <= ncx;
          chk_cy_r   <= ncy;
          chk_side_r <= !step_x;
          chk_perp_r <= step_x ? sdx_r : sdy_r;
        end
        hit_r <= hit_now;
        lh_r  <= 16'd0;
      end
      gdc_pkg::B_LH: begin
        // Zero distance divides to all ones and saturates too
        if (div_done) lh_r <= (div_quo > NW'(gdc_pkg::HEIGHT_MAX)) ? gdc_pkg::HEIGHT_MAX
                                                                   : div_quo[15:0];
      end
      gdc_pkg::B_DRAW: begin
        out_hit_r  <= hit_r;
        out_x_r    <= 6'(9'(chk_cx_r));
        out_y_r    <= 6'(9'(chk_cy_r));
        out_type_r <= rd_r;
        out_side_r <= chk_side_r;
        out_perp_r <= (chk_perp_r > SW'(gdc_pkg::PERP_MAX)) ? gdc_pkg::PERP_MAX
                                                              : chk_perp_r[22:0];
        out_lh_r   <= lh_r;
        out_ds_r   <= ds;
        out_de_r   <= de;
      end
      default: ;
    endcase
  end

  // Walk counters and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issued_r    <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == gdc_pkg::B_DRAW);
      if (state_r == gdc_pkg::B_SIDE) begin
        issued_r  <= '0;
        chk_vld_r <= 1'b0;
      end else if (state_r == gdc_pkg::B_WALK && !walk_end) begin
        issued_r  <= KW'(issued_r + 1'b1);
        chk_vld_r <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_wall_hit      = out_hit_r;
  assign out_hit_x         = out_x_r;
  assign out_hit_y         = out_y_r;
  assign out_wall_type     = out_type_r;
  assign out_hit_side      = out_side_r;
  assign out_perp_distance = out_perp_r;
  assign out_line_height   = out_lh_r;
  assign out_draw_start    = out_ds_r;
  assign out_draw_end      = out_de_r;

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe longer than one cycle");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issued_r <= KW'(MAX_STEPS)) else $error("walk exceeded step bound");
  a_hit_to_lh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdc_pkg::B_WALK && hit_now) |=> (state_r == gdc_pkg::B_LH))
    else $error("hit did not start line height division");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> (state_r == gdc_pkg::B_IDLE && item_vld))
    else $error("pop outside idle");

endmodule
